// ===== hdl/fadd_pkg.sv =====
`default_nettype none
package fadd_pkg;

  typedef struct packed {
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [31:0] sum_bits;
    logic        exponent_wrapped;
  } out_t;

  // aligned operands, stage 1 -> 2
  typedef struct packed {
    logic        bypass;
    logic [31:0] bypass_bits;
    logic        sa;
    logic        sb;
    logic [7:0]  exp;
    logic [23:0] ma;
    logic [23:0] mb;
  } align_t;

  // signed magnitude sum, stage 2 -> 3
  typedef struct packed {
    logic        bypass;
    logic [31:0] bypass_bits;
    logic        sign;
    logic [9:0]  exp;
    logic [24:0] mag;
  } sum_t;

endpackage
`default_nettype wire

// ===== hdl/float32_add_truncating_top.sv =====
// Pipeline: align, add and normalize results are registered in s1, s2 and out_data (valid bits v1, v2, out_valid).
// Throughput: one transfer per cycle; stall freezes the pipeline as a whole.
// Reset: rst (synchronous) clears all stage valid bits; data registers are not reset.
`default_nettype none
module float32_add_truncating_top (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire fadd_pkg::in_t    in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output fadd_pkg::out_t        out_data
);
  fadd_pkg::align_t a_next, s1;
  fadd_pkg::sum_t   m_next, s2;
  fadd_pkg::out_t   r_next;
  logic v1, v2, adv;

  fadd_align  u_align  (.in_item(in_data), .aligned(a_next));
  fadd_addsub u_addsub (.aligned(s1), .sum(m_next));
  fadd_norm   u_norm   (.sum(s2), .result(r_next));

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= a_next;
      s2 <= m_next;
      out_data <= r_next;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    adv && v2 |=> out_valid)
    else $error("stage 2 item lost");
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v1) && $stable(v2))
    else $error("pipeline moved under stall");
endmodule
`default_nettype wire

// ===== hdl/fadd_align.sv =====
`default_nettype none
module fadd_align (
  input  wire fadd_pkg::in_t    in_item,
  output fadd_pkg::align_t      aligned
);
  logic [7:0]  ea, eb, shift_amt;
  logic [23:0] ma, mb;
  logic        za, zb, a_small;

  always_comb begin
    ea = in_item.operand_a[30:23];
    eb = in_item.operand_b[30:23];
    ma = {1'b1, in_item.operand_a[22:0]};
    mb = {1'b1, in_item.operand_b[22:0]};
    za = (ea == 8'd0) && (in_item.operand_a[22:0] == 23'd0);
    zb = (eb == 8'd0) && (in_item.operand_b[22:0] == 23'd0);
    a_small = ea < eb;
    shift_amt = a_small ? (eb - ea) : (ea - eb);
    aligned.bypass = za || zb;
    aligned.bypass_bits = za ? in_item.operand_b : in_item.operand_a;
    aligned.sa = in_item.operand_a[31];
    aligned.sb = in_item.operand_b[31];
    aligned.exp = a_small ? eb : ea;
    aligned.ma = ma;
    aligned.mb = mb;
    if (a_small) begin
      aligned.ma = (shift_amt >= 8'd24) ? 24'd0 : (ma >> shift_amt);
    end else begin
      aligned.mb = (shift_amt >= 8'd24) ? 24'd0 : (mb >> shift_amt);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/fadd_addsub.sv =====
`default_nettype none
module fadd_addsub (
  input  wire fadd_pkg::align_t aligned,
  output fadd_pkg::sum_t        sum
);
  always_comb begin
    sum.bypass = aligned.bypass;
    sum.bypass_bits = aligned.bypass_bits;
    sum.exp = {2'b00, aligned.exp};
    if (aligned.sa == aligned.sb) begin
      sum.sign = aligned.sa;
      sum.mag = {1'b0, aligned.ma} + {1'b0, aligned.mb};
    end else if (aligned.ma > aligned.mb) begin
      sum.sign = aligned.sa;
      sum.mag = {1'b0, aligned.ma - aligned.mb};
    end else begin
      sum.sign = aligned.sb;
      sum.mag = {1'b0, aligned.mb - aligned.ma};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/fadd_norm.sv =====
`default_nettype none
module fadd_norm (
  input  wire fadd_pkg::sum_t sum,
  output fadd_pkg::out_t      result
);
  logic [23:0] m;
  logic [9:0]  e;
  logic [4:0]  lz;
  logic        found;

  always_comb begin
    if (sum.mag[24]) begin
      m = sum.mag[24:1];
      e = sum.exp + 10'd1;
    end else begin
      m = sum.mag[23:0];
      e = sum.exp;
    end
    lz = 5'd0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && m[i]) begin
        found = 1'b1;
        lz = 5'(23 - i);
      end
    end
    m = m << lz;
    e = e - {5'd0, lz};
    if (sum.bypass) begin
      result.sum_bits = sum.bypass_bits;
      result.exponent_wrapped = 1'b0;
    end else if (sum.mag == 25'd0) begin
      result.sum_bits = 32'd0;
      result.exponent_wrapped = 1'b0;
    end else begin
      result.sum_bits = {sum.sign, e[7:0], m[22:0]};
      result.exponent_wrapped = e[9] || e[8];
    end
  end
endmodule
`default_nettype wire
